FILE: design/threshold_pulse_width_meter_assert.svh
// assertion macros shared by the threshold pulse width meter checker
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef THRESHOLD_PULSE_WIDTH_METER_ASSERT_SVH
`define THRESHOLD_PULSE_WIDTH_METER_ASSERT_SVH

// checked only while out of reset
`define TPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TPWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tpwm_pkg.sv
// shared types and constants of the threshold pulse width meter
// no dependencies
package tpwm_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 8;

  localparam logic [11:0] LEVEL_MAX     = 12'd4095;
  localparam logic [11:0] THRESHOLD_RST = 12'd3200;
  localparam logic [11:0] FLOOR_RST     = 12'd500;

  // function codes of an input transaction
  localparam logic [1:0] FN_SAMPLE = 2'd0;
  localparam logic [1:0] FN_CLEAR  = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  // result kinds
  localparam logic KIND_COMMIT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_FLOOR     = 1'b1;

  // committed duration from the pulse tracker
  typedef struct packed {
    logic        req;
    logic [31:0] len;
  } tpwm_commit_t;

  // control of the history store
  typedef struct packed {
    logic        clr;
    logic        wr;
    logic [31:0] wr_data;
    logic        rd;
    logic [2:0]  rd_slot;
  } tpwm_hist_ctrl_t;

endpackage

FILE: design/tpwm_front.sv
// level conditioning and pulse phase tracker of the threshold pulse width meter
// depends on tpwm_pkg
module tpwm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [1:0]            func,
  input  logic [11:0]           adc_code,
  input  logic [31:0]           time_us,
  input  logic [11:0]           thr,
  input  logic [11:0]           dark_floor,
  output tpwm_pkg::tpwm_commit_t commit_o
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_OPEN = 3'b010,
    PH_DONE = 3'b100
  } tpwm_phase_t;

  tpwm_phase_t phase_r, phase_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [31:0] len_r, len_nxt;
  logic [11:0] raw_lvl, lvl;
  logic        above;

  // inverted code, forced to zero below the dark floor
  assign raw_lvl = tpwm_pkg::LEVEL_MAX - adc_code;
  assign lvl     = (raw_lvl >= dark_floor) ? raw_lvl : 12'd0;
  assign above   = (lvl >= thr);

  assign commit_o.req = acc && (func == tpwm_pkg::FN_SAMPLE) && (phase_r == PH_DONE);
  assign commit_o.len = len_r;

  always_comb begin
    phase_nxt = phase_r;
    stamp_nxt = stamp_r;
    len_nxt   = len_r;
    if (acc) begin
      unique case (func)
        tpwm_pkg::FN_CLEAR: begin
          phase_nxt = PH_WAIT;
          stamp_nxt = 32'd0;
          len_nxt   = 32'd0;
        end
        tpwm_pkg::FN_SAMPLE: begin
          unique case (phase_r)
            PH_DONE: begin
              phase_nxt = PH_WAIT;
              stamp_nxt = 32'd0;
              len_nxt   = 32'd0;
            end
            PH_OPEN: begin
              if (!above) begin
                len_nxt   = time_us - stamp_r;
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              if (above) begin
                stamp_nxt = time_us;
                phase_nxt = PH_OPEN;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      stamp_r <= 32'd0;
      len_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      stamp_r <= stamp_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

FILE: design/tpwm_hist.sv
// ring of recent durations with registered read-back
// depends on tpwm_pkg
module tpwm_hist #(
  parameter int unsigned HISTORY_DEPTH = tpwm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tpwm_pkg::tpwm_hist_ctrl_t ctrl,
  output logic [31:0]               rd_data_r,
  output logic                      rd_hit_r,
  output logic [2:0]                wr_slot
);

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  logic [31:0]              mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_r, vld_nxt;
  logic [IDX_W-1:0]         ws_r, ws_nxt;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_in_range;

  assign rd_idx      = IDX_W'(ctrl.rd_slot);
  assign rd_in_range = (7'(ctrl.rd_slot) < 7'(HISTORY_DEPTH));
  assign wr_slot     = 3'(ws_r);

  always_comb begin
    vld_nxt = vld_r;
    ws_nxt  = ws_r;
    if (ctrl.clr) begin
      vld_nxt = '0;
      ws_nxt  = '0;
    end else if (ctrl.wr) begin
      vld_nxt[ws_r] = 1'b1;
      ws_nxt        = (ws_r == LAST_IDX) ? '0 : ws_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ws_r     <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      ws_r  <= ws_nxt;
      if (ctrl.rd) begin
        rd_hit_r <= rd_in_range && vld_r[rd_idx];
      end
    end
  end

  // write and registered read of the store
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[ws_r] <= ctrl.wr_data;
    end
    if (ctrl.rd) begin
      rd_data_r <= mem[rd_idx];
    end
  end

endmodule

FILE: design/threshold_pulse_width_meter.sv
// threshold pulse width meter, top level; depends on tpwm_pkg, tpwm_front, tpwm_hist
// a result passes the middle stage and then the output register before it appears on out_valid
// throughput: one input transaction per cycle while the result side takes its results
// clear transactions and plain samples update state at acceptance and produce no result
// reset (rst_n low, synchronous): registers to defaults, history emptied, pipeline empty
// history is emptied by per-slot valid bits, so no clearing pass follows reset
module threshold_pulse_width_meter #(
  parameter int unsigned HISTORY_DEPTH = tpwm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_adc_code,
  input  logic [31:0] in_time_us,
  input  logic [2:0]  in_read_slot,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_duration_us,
  output logic [2:0]  out_slot
);

  // configuration registers
  logic [11:0] thr_r;
  logic [11:0] floor_r;

  // transaction accepted on the input side
  logic in_acc;

  tpwm_pkg::tpwm_commit_t    commit;
  tpwm_pkg::tpwm_hist_ctrl_t hctrl;
  logic [31:0]               rd_data;
  logic                      rd_hit;
  logic [2:0]                wr_slot;

  // middle stage: one result in flight, read data lands next to it
  logic        a_valid_r, a_valid_nxt;
  logic        a_kind_r;
  logic [2:0]  a_slot_r;
  logic [31:0] a_len_r;
  logic        a_adv;
  logic        a_load;
  logic        is_read;

  // output register
  logic        o_valid_r, o_valid_nxt;
  logic        o_kind_r;
  logic [2:0]  o_slot_r;
  logic [31:0] o_dur_r;
  logic [31:0] a_dur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= tpwm_pkg::THRESHOLD_RST;
      floor_r <= tpwm_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpwm_pkg::CFG_THRESHOLD: thr_r   <= cfg_wdata;
        tpwm_pkg::CFG_FLOOR:     floor_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // the middle stage moves on when the output register is empty or being drained
  assign a_adv    = a_valid_r && (!o_valid_r || !out_stall);
  // hold the input only while a result sits in the middle stage with nowhere to go
  assign in_stall = a_valid_r && !a_adv;
  assign in_acc   = in_valid && !in_stall;

  tpwm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .func       (in_func),
    .adc_code   (in_adc_code),
    .time_us    (in_time_us),
    .thr        (thr_r),
    .dark_floor (floor_r),
    .commit_o   (commit)
  );

  assign is_read = in_acc && (in_func == tpwm_pkg::FN_READ);

  always_comb begin
    hctrl.clr     = in_acc && (in_func == tpwm_pkg::FN_CLEAR);
    hctrl.wr      = commit.req;
    hctrl.wr_data = commit.len;
    hctrl.rd      = is_read;
    hctrl.rd_slot = in_read_slot;
  end

  tpwm_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (hctrl),
    .rd_data_r (rd_data),
    .rd_hit_r  (rd_hit),
    .wr_slot   (wr_slot)
  );

  // only commits and reads enter the middle stage
  assign a_load = commit.req || is_read;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_kind_r <= is_read ? tpwm_pkg::KIND_READ : tpwm_pkg::KIND_COMMIT;
      a_slot_r <= is_read ? in_read_slot : wr_slot;
      a_len_r  <= commit.len;
    end
  end

  // an empty or out-of-range slot reads as zero
  assign a_dur = (a_kind_r == tpwm_pkg::KIND_READ) ? (rd_hit ? rd_data : 32'd0) : a_len_r;

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (a_adv) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      o_kind_r <= a_kind_r;
      o_slot_r <= a_slot_r;
      o_dur_r  <= a_dur;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_kind        = o_kind_r;
  assign out_slot        = o_slot_r;
  assign out_duration_us = o_dur_r;

endmodule

FILE: design/tpwm_checker.sv
// port-level checks of the threshold pulse width meter, bound to the top level
// depends on threshold_pulse_width_meter_assert.svh and the top level's ports
`include "threshold_pulse_width_meter_assert.svh"

module tpwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [11:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_func,
  input logic [11:0] in_adc_code,
  input logic [31:0] in_time_us,
  input logic [2:0]  in_read_slot,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [31:0] out_duration_us,
  input logic [2:0]  out_slot
);

  // a held result stays offered
  `TPWM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // a held result keeps its duration
  `TPWM_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_duration_us), "stalled result changed")

  // input back-pressure only comes from a full, stalled result side
  `TPWM_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with result side free")

  // reset empties the result side
  `TPWM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind threshold_pulse_width_meter tpwm_checker u_tpwm_checker (.*);

FILE: tb/sv/tb_threshold_pulse_width_meter.sv
// self-checking bench for the threshold pulse width meter: directed and random transactions,
// an in-bench prediction of every result, bursty sender and stalling receiver
// depends on tpwm_pkg and threshold_pulse_width_meter
`timescale 1ns / 100ps

module tb_threshold_pulse_width_meter;
  import tpwm_pkg::*;

  localparam int unsigned DEPTH         = HISTORY_DEPTH_DEF;
  localparam logic [1:0]  FN_SPARE      = 2'd3;   // unused function code, ignored by the block
  localparam int unsigned SETTLE_CYCLES = 6;      // margin for the result pipeline to empty
  localparam int unsigned LONG_HOLD     = 300;    // receiver hold-off that backs up the block
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned NUM_PHASES    = 7;
  localparam longint      LIMIT_NS      = 2_000_000;

  // pulse tracking states of the meter
  typedef enum logic [1:0] {
    MS_WAIT     = 2'd0,
    MS_OPEN     = 2'd1,
    MS_CAPTURED = 2'd2
  } meter_phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] duration;
    logic [2:0]  slot;
  } meter_result_t;

  // shadow of the meter: predicts each result and checks it in order
  class pulse_width_tracker;
    logic [11:0]   threshold;
    logic [11:0]   dark_floor;
    meter_phase_t  phase;
    logic [31:0]   open_stamp;
    logic [31:0]   pulse_len;
    logic [31:0]   history [DEPTH];
    int unsigned   wr_slot;
    meter_result_t owed_results[$];
    int unsigned   failures;

    function new();
      threshold  = THRESHOLD_RST;
      dark_floor = FLOOR_RST;
      failures   = 0;
      wipe();
    endfunction

    function void wipe();
      phase      = MS_WAIT;
      open_stamp = '0;
      pulse_len  = '0;
      for (int i = 0; i < DEPTH; i++) history[i] = '0;
      wr_slot    = 0;
    endfunction

    function void set_regs(logic [11:0] thr, logic [11:0] flr);
      threshold  = thr;
      dark_floor = flr;
    endfunction

    function int unsigned owed_count();
      return owed_results.size();
    endfunction

    // one accepted input transaction
    function void note_transaction(logic [1:0] fn, logic [11:0] code, logic [31:0] stamp,
                                   logic [2:0] rs);
      logic [11:0]   lvl;
      meter_result_t r;
      int unsigned   ws;
      case (fn)
        FN_CLEAR: begin
          wipe();
        end
        FN_READ: begin
          r.kind     = KIND_READ;
          r.duration = (rs < DEPTH) ? history[rs] : '0;
          r.slot     = rs;
          owed_results.push_back(r);
        end
        FN_SAMPLE: begin
          lvl = LEVEL_MAX - code;
          if (lvl < dark_floor) lvl = '0;
          case (phase)
            MS_CAPTURED: begin
              // commit sample: never examined for a new opening
              ws          = (wr_slot < DEPTH) ? wr_slot : 0;
              history[ws] = pulse_len;
              r.kind      = KIND_COMMIT;
              r.duration  = pulse_len;
              r.slot      = 3'(ws);
              owed_results.push_back(r);
              wr_slot     = (ws + 1 >= DEPTH) ? 0 : ws + 1;
              phase       = MS_WAIT;
              open_stamp  = '0;
              pulse_len   = '0;
            end
            MS_OPEN: begin
              if (lvl < threshold) begin
                pulse_len = stamp - open_stamp;
                phase     = MS_CAPTURED;
              end
            end
            default: begin
              if (lvl >= threshold) begin
                open_stamp = stamp;
                phase      = MS_OPEN;
              end
            end
          endcase
        end
        default: ;
      endcase
    endfunction

    // one accepted result transaction against the oldest owed one
    function void check_result(logic kind, logic [31:0] dur, logic [2:0] slot);
      meter_result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result: kind %0d duration_us %0d slot %0d", kind, dur, slot);
        failures++;
      end else begin
        want = owed_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          failures++;
        end
        if (dur !== want.duration) begin
          $error("duration_us: expected %0d, actual %0d", want.duration, dur);
          failures++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot);
          failures++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [11:0] in_adc_code;
  logic [31:0] in_time_us;
  logic [2:0]  in_read_slot;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [31:0] out_duration_us;
  logic [2:0]  out_slot;

  pulse_width_tracker sb;

  int unsigned items_sent;   // counts transactions the block acts on
  int unsigned burst_left;   // sender transactions left before the next gap
  logic [31:0] now_us;       // running timestamp
  logic [11:0] thr_now;      // threshold of the current phase, steers stimulus
  bit          hold_off_req; // asks the receiver for one long hold-off

  threshold_pulse_width_meter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_adc_code     (in_adc_code),
    .in_time_us      (in_time_us),
    .in_read_slot    (in_read_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_duration_us (out_duration_us),
    .out_slot        (out_slot)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both handshakes sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_kind, out_duration_us, out_slot);
      if (in_valid && !in_stall) sb.note_transaction(in_func, in_adc_code, in_time_us,
                                                     in_read_slot);
    end
  end

  // receiver: stretches of no stall, light, heavy and periodic stall, plus one long hold-off
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int unsigned k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((k % 8) < 3);
        endcase
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] next_stamp();
    // mostly small steps, zero included; now and then a jump anywhere so wrap occurs
    if ($urandom_range(0, 15) == 0) now_us = $urandom;
    else now_us = now_us + $urandom_range(0, 3000);
    return now_us;
  endfunction

  // converter code for a light level at/above or below the phase threshold
  function automatic logic [11:0] level_code(bit want_high);
    int unsigned lvl;
    if (want_high) lvl = $urandom_range(4095, thr_now);
    else if (thr_now == 0) lvl = $urandom_range(4095, 0);
    else lvl = $urandom_range(thr_now - 1, 0);
    return LEVEL_MAX - 12'(lvl);
  endfunction

  // offers one transaction, keeps valid up until accepted; gaps between bursts
  task automatic offer(input logic [1:0] fn, input logic [11:0] code, input logic [31:0] stamp,
                       input logic [2:0] rs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_adc_code  <= code;
    in_time_us   <= stamp;
    in_read_slot <= rs;
    do @(posedge clk); while (in_stall);
    if (fn != FN_SPARE) items_sent++;
  endtask

  task automatic sample(input logic [11:0] code, input logic [31:0] stamp);
    offer(FN_SAMPLE, code, stamp, 3'($urandom_range(0, 7)));
  endtask

  task automatic read_slot(input logic [2:0] rs);
    offer(FN_READ, 12'($urandom), $urandom, rs);
  endtask

  // stop offering, wait for every owed result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed_count() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic load_regs(input logic [11:0] thr, input logic [11:0] flr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= CFG_FLOOR;
    cfg_wdata <= flr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_regs(thr, flr);
    thr_now = thr;
  endtask

  // well-formed pulse: some dark, open, some lit, close, then the commit sample
  task automatic pulse_sequence();
    int unsigned n_low;
    int unsigned n_high;
    n_low  = $urandom_range(0, 2);
    n_high = $urandom_range(0, 3);
    repeat (n_low) sample(level_code(1'b0), next_stamp());
    sample(level_code(1'b1), next_stamp());
    repeat (n_high) sample(level_code(1'b1), next_stamp());
    sample(level_code(1'b0), next_stamp());
    sample(12'($urandom), next_stamp());
  endtask

  task automatic random_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) pulse_sequence();
    else if (pick < 80) read_slot(3'($urandom_range(0, 7)));
    else if (pick < 85) offer(FN_CLEAR, 12'($urandom), $urandom, 3'($urandom));
    else if (pick < 90) offer(FN_SPARE, 12'($urandom), $urandom, 3'($urandom));
    else sample(12'($urandom), next_stamp());
  endtask

  initial begin : stimulus
    int unsigned ph;
    logic [11:0] t;
    logic [11:0] f;
    sb           = new();
    items_sent   = 0;
    burst_left   = 0;
    now_us       = '0;
    thr_now      = THRESHOLD_RST;
    hold_off_req = 1'b0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_THRESHOLD;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_func      <= FN_SAMPLE;
    in_adc_code  <= '0;
    in_time_us   <= '0;
    in_read_slot <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    read_slot(3'd0);                      // empty history reads zero
    read_slot(3'd7);
    sample(12'd0, 32'd0);                 // full light opens at timestamp zero
    sample(12'd4095, 32'd0);              // zero duration captured
    sample(12'd0, 32'd5);                 // commit sample, bright but must not open
    sample(12'd4095, 32'd6);
    sample(12'd895, 32'hFFFF_FFF0);       // level exactly at threshold opens
    sample(12'd896, 32'h0000_0010);       // one below closes, duration wraps
    offer(FN_SPARE, 12'd0, 32'd1, 3'd7);  // ignored code
    sample(12'd4095, 32'hFFFF_FFFF);      // commits into slot one
    read_slot(3'd1);
    sample(12'd0, 32'd7);                 // open, then clear drops it
    offer(FN_CLEAR, 12'hFFF, 32'hFFFF_FFFF, 3'd7);
    sample(12'd4095, 32'd9);
    sample(12'd4095, 32'd11);
    read_slot(3'd1);                      // history emptied by the clear
    settle();

    // low threshold under the dark floor: floor decides what counts as light
    load_regs(12'd100, 12'd500);
    sample(12'd3596, 32'd100);            // level 499 forced to zero, stays waiting
    sample(12'd3595, 32'd100);            // level 500 opens
    sample(12'd3596, 32'd350);            // closes after 250
    sample(12'd0, 32'd400);               // commits
    read_slot(3'd0);
    sample(12'd0, 32'd500);
    sample(12'd4095, 32'd600);            // captured, then cleared before commit
    offer(FN_CLEAR, 12'd0, 32'd0, 3'd0);
    sample(12'd0, 32'd700);               // opens again rather than committing

    // random phases across register settings, extremes first
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin t = THRESHOLD_RST; f = FLOOR_RST; end
        1:       begin t = 12'd0;    f = 12'd0;    end
        2:       begin t = 12'd4095; f = 12'd4095; end
        3:       begin t = 12'd4095; f = 12'd0;    end
        4:       begin t = 12'd0;    f = 12'd4095; end
        default: begin t = 12'($urandom); f = 12'($urandom); end
      endcase
      settle();
      load_regs(t, f);
      if (ph == 0) hold_off_req = 1'b1;   // back the block up while items keep coming
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) random_step();
    end

    settle();
    if (sb.failures == 0 && sb.owed_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
